// File: design/scrle_pkg.sv
package scrle_pkg;

    // Image and field geometry
    localparam int MAX_DIM   = 4096;
    localparam int DIM_W     = 13;
    localparam int COL_W     = 12;
    localparam int LISTED_W  = 14;
    localparam int PIX_W     = 24;
    localparam int WORD_W    = 32;
    localparam int PITCH_W   = 16;
    localparam int KEY_W     = 24;
    localparam int PIX565_W  = 16;
    localparam int KIND_W    = 3;
    localparam int NTOK      = 6;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    // Configuration port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam logic [1:0] REG_PITCH  = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;
    localparam logic [1:0] REG_KEY    = 2'd3;

    localparam logic [PITCH_W-1:0] PITCH_RESET  = 16'd1280;
    localparam logic [DIM_W-1:0]   WIDTH_RESET  = 13'd64;
    localparam logic [DIM_W-1:0]   HEIGHT_RESET = 13'd64;
    localparam logic [KEY_W-1:0]   KEY_RESET    = 24'd0;

    localparam logic [WORD_W-1:0] ROW_CHANGED_BIT = 32'h8000_0000;
    localparam logic [WORD_W-1:0] TERMINATOR_WORD = 32'hffff_ffff;

    // Token kinds; the code doubles as the bit position in the back's token mask
    typedef enum logic [KIND_W-1:0] {
        KIND_SKIP   = 3'd0,
        KIND_RANGE  = 3'd1,
        KIND_PIXEL  = 3'd2,
        KIND_LENGTH = 3'd3,
        KIND_TERM   = 3'd4,
        KIND_NULL   = 3'd5
    } t_kind;

    typedef struct packed {
        logic [PITCH_W-1:0] pitch;
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
        logic [KEY_W-1:0]   key;
    } t_cfg;

    // One classified pixel: which tokens it causes and their raw operands
    typedef struct packed {
        logic                open;
        logic                row_changed;
        logic [DIM_W-1:0]    row_delta;
        logic [DIM_W:0]      col_delta;
        logic [DIM_W-1:0]    range_first;
        logic [DIM_W-1:0]    range_last;
        logic [COL_W-1:0]    run_column;
        logic                pixel;
        logic [PIX565_W-1:0] pix565;
        logic                close;
        logic [DIM_W-1:0]    length;
        logic                fin;
        logic [DIM_W-1:0]    null_first;
        logic [DIM_W-1:0]    null_last;
    } t_cmd;

    // Clamp a dimension register to 1..MAX_DIM
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > DIM_W'(MAX_DIM)) begin
            r = DIM_W'(MAX_DIM);
        end
        return r;
    endfunction

    // 24-bit RGB-in-word pixel (red in the top byte) to RGB565
    function automatic logic [PIX565_W-1:0] pack565(input logic [PIX_W-1:0] p);
        return {p[23:19], p[15:10], p[7:3]};
    endfunction

endpackage

// File: design/scrle_if.sv
interface scrle_pix_if;
    logic                          valid;
    logic                          ready;
    logic [scrle_pkg::PIX_W-1:0]   pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface scrle_tok_if;
    logic                          valid;
    logic                          ready;
    logic [scrle_pkg::KIND_W-1:0]  kind;
    logic [scrle_pkg::WORD_W-1:0]  word;
    logic [scrle_pkg::DIM_W-1:0]   row_first;
    logic [scrle_pkg::DIM_W-1:0]   row_last;
    logic [scrle_pkg::COL_W-1:0]   run_column;
    logic                          last;

    modport source (output valid, output kind, output word, output row_first,
                    output row_last, output run_column, output last, input ready);
    modport sink   (input valid, input kind, input word, input row_first,
                    input row_last, input run_column, input last, output ready);
endinterface

// File: design/scrle_front.sv
module scrle_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  scrle_pkg::t_cfg   i_cfg,
    scrle_pix_if.sink         i_pix,
    input  logic              i_full,
    output logic              o_push,
    output scrle_pkg::t_cmd   o_cmd
);

    logic [scrle_pkg::COL_W-1:0]    r_column,    n_column;
    logic [scrle_pkg::DIM_W-1:0]    r_row,       n_row;
    logic [scrle_pkg::DIM_W-1:0]    r_prev_col,  n_prev_col;
    logic [scrle_pkg::DIM_W-1:0]    r_prev_row,  n_prev_row;
    logic [scrle_pkg::LISTED_W-1:0] r_listed,    n_listed;
    logic                           r_in_run,    n_in_run;

    logic                           accept;
    logic                           opaque, open, close_tr, close_re, row_end, img_end;
    logic [scrle_pkg::DIM_W-1:0]    w, h, col_ext, col_next, row_next, prev_col_eff;
    logic [scrle_pkg::LISTED_W-1:0] listed_eff, listed_inc, listed_eff_inc;

    assign i_pix.ready = !i_full;
    assign accept      = i_pix.valid && !i_full;

    // Classify the pixel against the current position
    always_comb begin
        w              = scrle_pkg::clamp_dim(i_cfg.width);
        h              = scrle_pkg::clamp_dim(i_cfg.height);
        col_ext        = {1'b0, r_column};
        col_next       = col_ext + scrle_pkg::DIM_W'(1);
        row_next       = r_row + scrle_pkg::DIM_W'(1);
        opaque         = (i_pix.pixel != i_cfg.key);
        open           = opaque && !r_in_run;
        close_tr       = !opaque && r_in_run;
        row_end        = (col_next >= w);
        img_end        = row_end && (row_next >= h);
        close_re       = row_end && opaque;
        prev_col_eff   = open ? col_ext : r_prev_col;
        listed_eff     = open ? {1'b0, r_row} : r_listed;
        listed_inc     = r_listed + scrle_pkg::LISTED_W'(1);
        listed_eff_inc = listed_eff + scrle_pkg::LISTED_W'(1);
    end

    // Build the command word for the queue
    always_comb begin
        o_cmd.open        = open;
        o_cmd.row_changed = (r_row != r_prev_row);
        o_cmd.row_delta   = r_row - r_prev_row;
        o_cmd.col_delta   = {1'b0, col_ext} - {1'b0, r_prev_col};
        o_cmd.range_first = listed_inc[scrle_pkg::DIM_W-1:0];
        o_cmd.range_last  = r_row;
        o_cmd.run_column  = r_column;
        o_cmd.pixel       = opaque;
        o_cmd.pix565      = scrle_pkg::pack565(i_pix.pixel);
        o_cmd.close       = close_tr || close_re;
        o_cmd.length      = close_tr ? (col_ext - r_prev_col) : (col_next - prev_col_eff);
        o_cmd.fin         = img_end;
        o_cmd.null_first  = listed_eff_inc[scrle_pkg::DIM_W-1:0];
        o_cmd.null_last   = h;
        o_push            = accept && (opaque || close_tr || img_end);
    end

    // Advance the raster position and run bookkeeping
    always_comb begin
        n_column   = r_column;
        n_row      = r_row;
        n_prev_col = r_prev_col;
        n_prev_row = r_prev_row;
        n_listed   = r_listed;
        n_in_run   = r_in_run;
        if (accept) begin
            priority if (img_end) begin
                n_column   = '0;
                n_row      = '0;
                n_prev_col = '0;
                n_prev_row = '0;
                n_listed   = '1;
                n_in_run   = 1'b0;
            end else begin
                n_column = row_end ? '0 : col_next[scrle_pkg::COL_W-1:0];
                n_row    = row_end ? row_next : r_row;
                n_in_run = opaque && !row_end;
                if (open) begin
                    n_listed = {1'b0, r_row};
                end
                priority if (close_re) begin
                    n_prev_col = col_next;
                    n_prev_row = r_row;
                end else if (close_tr || open) begin
                    n_prev_col = col_ext;
                    n_prev_row = r_row;
                end else begin
                    n_prev_col = r_prev_col;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column   <= '0;
            r_row      <= '0;
            r_prev_col <= '0;
            r_prev_row <= '0;
            r_listed   <= '1;
            r_in_run   <= 1'b0;
        end else begin
            r_column   <= n_column;
            r_row      <= n_row;
            r_prev_col <= n_prev_col;
            r_prev_row <= n_prev_row;
            r_listed   <= n_listed;
            r_in_run   <= n_in_run;
        end
    end

endmodule

// File: design/scrle_fifo.sv
module scrle_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  scrle_pkg::t_cmd   i_cmd,
    input  logic              i_pop,
    output scrle_pkg::t_cmd   o_cmd,
    output logic              o_empty,
    output logic              o_full
);

    scrle_pkg::t_cmd                r_mem [scrle_pkg::QUEUE_DEPTH];
    logic [scrle_pkg::QPTR_W-1:0]   r_wptr, r_rptr;
    logic [scrle_pkg::QPTR_W:0]     r_count;

    assign o_cmd   = r_mem[r_rptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (scrle_pkg::QPTR_W+1)'(scrle_pkg::QUEUE_DEPTH));

    // Store command words
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    // Move pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + scrle_pkg::QPTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + scrle_pkg::QPTR_W'(1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (scrle_pkg::QPTR_W+1)'(1);
                2'b01:   r_count <= r_count - (scrle_pkg::QPTR_W+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: design/scrle_back.sv
module scrle_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [scrle_pkg::PITCH_W-1:0]     i_pitch,
    input  scrle_pkg::t_cmd                   i_cmd,
    input  logic                              i_empty,
    output logic                              o_pop,
    scrle_tok_if.source                       o_tok
);

    logic                              r_valid;
    scrle_pkg::t_kind                  r_kind;
    logic [scrle_pkg::WORD_W-1:0]      r_word;
    logic [scrle_pkg::DIM_W-1:0]       r_first, r_last;
    logic [scrle_pkg::COL_W-1:0]       r_col;
    logic                              r_fin;
    logic [scrle_pkg::NTOK-1:0]        r_done, n_done;

    logic                              load;
    logic [scrle_pkg::NTOK-1:0]        mask, rem, sel, left;
    scrle_pkg::t_kind                  kind;
    logic [scrle_pkg::WORD_W-1:0]      prod, skip_word;
    logic [scrle_pkg::WORD_W-1:0]      word;
    logic [scrle_pkg::DIM_W-1:0]       first, last_row;
    logic [scrle_pkg::COL_W-1:0]       col;
    logic                              fin;

    assign o_tok.valid      = r_valid;
    assign o_tok.kind       = r_kind;
    assign o_tok.word       = r_word;
    assign o_tok.row_first  = r_first;
    assign o_tok.row_last   = r_last;
    assign o_tok.run_column = r_col;
    assign o_tok.last       = r_fin;

    // Pick the next outstanding token of the head command
    always_comb begin
        mask = {i_cmd.fin, i_cmd.fin, i_cmd.close, i_cmd.pixel, i_cmd.open, i_cmd.open};
        rem  = mask & ~r_done;
        priority if (rem[scrle_pkg::KIND_SKIP]) begin
            kind = scrle_pkg::KIND_SKIP;
        end else if (rem[scrle_pkg::KIND_RANGE]) begin
            kind = scrle_pkg::KIND_RANGE;
        end else if (rem[scrle_pkg::KIND_PIXEL]) begin
            kind = scrle_pkg::KIND_PIXEL;
        end else if (rem[scrle_pkg::KIND_LENGTH]) begin
            kind = scrle_pkg::KIND_LENGTH;
        end else if (rem[scrle_pkg::KIND_TERM]) begin
            kind = scrle_pkg::KIND_TERM;
        end else begin
            kind = scrle_pkg::KIND_NULL;
        end
        sel   = scrle_pkg::NTOK'(1) << kind;
        left  = rem & ~sel;
        load  = !i_empty && (!r_valid || o_tok.ready);
        o_pop = load && (left == '0);
    end

    // Skip word: row delta times pitch plus twice the signed column delta, bit 31 set on a row change
    always_comb begin
        prod      = scrle_pkg::WORD_W'(i_pitch) * scrle_pkg::WORD_W'(i_cmd.row_delta);
        skip_word = prod + {{(scrle_pkg::WORD_W-scrle_pkg::DIM_W-2){i_cmd.col_delta[scrle_pkg::DIM_W]}},
                            i_cmd.col_delta, 1'b0};
        if (i_cmd.row_changed) begin
            skip_word = skip_word | scrle_pkg::ROW_CHANGED_BIT;
        end
    end

    // Form the token payload
    always_comb begin
        word     = '0;
        first    = '0;
        last_row = '0;
        col      = '0;
        fin      = 1'b0;
        unique case (kind)
            scrle_pkg::KIND_SKIP: begin
                word = skip_word;
            end
            scrle_pkg::KIND_RANGE: begin
                first    = i_cmd.range_first;
                last_row = i_cmd.range_last;
                col      = i_cmd.run_column;
            end
            scrle_pkg::KIND_PIXEL: begin
                word = scrle_pkg::WORD_W'(i_cmd.pix565);
            end
            scrle_pkg::KIND_LENGTH: begin
                word = scrle_pkg::WORD_W'({i_cmd.length, 1'b0});
            end
            scrle_pkg::KIND_TERM: begin
                word = scrle_pkg::TERMINATOR_WORD;
            end
            scrle_pkg::KIND_NULL: begin
                first    = i_cmd.null_first;
                last_row = i_cmd.null_last;
                fin      = 1'b1;
            end
            default: begin
                word = '0;
            end
        endcase
    end

    // Track tokens already sent for the head command
    always_comb begin
        n_done = r_done;
        if (load) begin
            n_done = (left == '0) ? '0 : (r_done | sel);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_done  <= '0;
        end else begin
            r_done <= n_done;
            if (load) begin
                r_valid <= 1'b1;
            end else if (o_tok.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Hold the output word until taken
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind  <= kind;
            r_word  <= word;
            r_first <= first;
            r_last  <= last_row;
            r_col   <= col;
            r_fin   <= fin;
        end
    end

endmodule

// File: design/sprite_colour_key_rle_encoder_top.sv
// Colour-key run-length encoder for sprites.
// i_pix carries one 24-bit pixel per word in raster order; o_tok carries
// tokens (skip, row range, RGB565 pixel, length, terminator, null range).
// Pixels equal to the key colour are dropped; each opaque run gives a skip
// word, a row range, its pixel words and a length word; the image ends with a
// terminator and a null range flagged with last.
// The front classifies one pixel per cycle while the queue has room and, for
// each pixel that causes tokens, pushes a command into a 4-entry queue; the
// back expands each command into 1 to 6 tokens, one token per cycle through
// an output register while the receiver takes them. So the sustained rate is
// set by the token port and by how many tokens each pixel causes: up to 6 for
// a pixel that opens a run and ends the image, 1 for a plain opaque pixel.
// When the receiver stalls, the token holds, the queue fills and i_pix.ready
// drops. Synchronous reset clears position, queue and output valid, and loads
// the default registers (pitch 1280, 64 x 64, key 0). The user must write
// registers through the APB port only while the block is idle; the block
// itself does not enforce this.
module sprite_colour_key_rle_encoder_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    scrle_pix_if.sink                         i_pix,
    scrle_tok_if.source                       o_tok,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [scrle_pkg::PADDR_W-1:0]     paddr,
    input  logic [scrle_pkg::PDATA_W-1:0]     pwdata,
    output logic [scrle_pkg::PDATA_W-1:0]     prdata,
    output logic                              pready
);

    logic [scrle_pkg::PITCH_W-1:0] r_pitch;
    logic [scrle_pkg::DIM_W-1:0]   r_width;
    logic [scrle_pkg::DIM_W-1:0]   r_height;
    logic [scrle_pkg::KEY_W-1:0]   r_key;

    scrle_pkg::t_cfg cfg;
    scrle_pkg::t_cmd push_cmd, head_cmd;
    logic            push, pop, q_empty, q_full, wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = '{pitch: r_pitch, width: r_width, height: r_height, key: r_key};

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pitch  <= scrle_pkg::PITCH_RESET;
            r_width  <= scrle_pkg::WIDTH_RESET;
            r_height <= scrle_pkg::HEIGHT_RESET;
            r_key    <= scrle_pkg::KEY_RESET;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                scrle_pkg::REG_PITCH:  r_pitch  <= pwdata[scrle_pkg::PITCH_W-1:0];
                scrle_pkg::REG_WIDTH:  r_width  <= pwdata[scrle_pkg::DIM_W-1:0];
                scrle_pkg::REG_HEIGHT: r_height <= pwdata[scrle_pkg::DIM_W-1:0];
                scrle_pkg::REG_KEY:    r_key    <= pwdata[scrle_pkg::KEY_W-1:0];
                default:               r_key    <= r_key;
            endcase
        end
    end

    // Read back configuration registers
    always_comb begin
        unique case (paddr[3:2])
            scrle_pkg::REG_PITCH:  prdata = scrle_pkg::PDATA_W'(r_pitch);
            scrle_pkg::REG_WIDTH:  prdata = scrle_pkg::PDATA_W'(r_width);
            scrle_pkg::REG_HEIGHT: prdata = scrle_pkg::PDATA_W'(r_height);
            scrle_pkg::REG_KEY:    prdata = scrle_pkg::PDATA_W'(r_key);
            default:               prdata = '0;
        endcase
    end

    scrle_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_pix   (i_pix),
        .i_full  (q_full),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    scrle_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    scrle_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pitch (r_pitch),
        .i_cmd   (head_cmd),
        .i_empty (q_empty),
        .o_pop   (pop),
        .o_tok   (o_tok)
    );

`ifndef SYNTHESIS
    // The front never pushes into a full queue
    assert property (@(posedge i_clk) disable iff (!i_rst_n) push |-> !q_full)
        else $error("command pushed into full queue");

    // The back never pops an empty queue
    assert property (@(posedge i_clk) disable iff (!i_rst_n) pop |-> !q_empty)
        else $error("command popped from empty queue");

    // Only the null range closes the image
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tok.valid && o_tok.last) |-> (o_tok.kind == scrle_pkg::KIND_NULL))
        else $error("last flag on a token other than the null range");
`endif

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import scrle_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int MAX_WAIT       = 10;
    localparam int PRINT_LIMIT    = 100;
    localparam int RANDOM_PHASES  = 5;
    localparam int PHASE_PIXELS   = 18;

    // Mixed runs for a 3 x 2 image keyed on white
    localparam logic [PIX_W-1:0] RUN_PIXELS [12] = '{
        24'h000000, 24'hffffff, 24'h00ff00, 24'hff0000, 24'h0000ff, 24'hffffff,
        24'h808080, 24'h7f7f7f, 24'hffffff, 24'hffffff, 24'h010203, 24'hfefdfc
    };

    typedef struct packed {
        t_kind              kind;
        logic [WORD_W-1:0]  word;
        logic [DIM_W-1:0]   row_first;
        logic [DIM_W-1:0]   row_last;
        logic [COL_W-1:0]   run_column;
        logic               last;
    } rle_token_t;

    // Token predictor and checker for the encoder
    class rle_token_scoreboard;
        logic [PITCH_W-1:0] pitch_cfg;
        logic [DIM_W-1:0]   width_cfg;
        logic [DIM_W-1:0]   height_cfg;
        logic [KEY_W-1:0]   key_cfg;

        logic [31:0] col_pos;
        logic [31:0] row_pos;
        logic [31:0] mark_col;
        logic [31:0] mark_row;
        logic [31:0] listed_row;
        bit          run_open;

        rle_token_t due_tokens[$];
        int         mismatch_count;

        function new();
            pitch_cfg      = PITCH_RESET;
            width_cfg      = WIDTH_RESET;
            height_cfg     = HEIGHT_RESET;
            key_cfg        = KEY_RESET;
            mismatch_count = 0;
            restart();
        endfunction

        function void restart();
            col_pos    = '0;
            row_pos    = '0;
            mark_col   = '0;
            mark_row   = '0;
            listed_row = '1;
            run_open   = 1'b0;
        endfunction

        function void set_register(input logic [1:0] reg_index,
                                   input logic [PDATA_W-1:0] value);
            case (reg_index)
                REG_PITCH: begin
                    pitch_cfg = value[PITCH_W-1:0];
                end
                REG_WIDTH: begin
                    width_cfg = value[DIM_W-1:0];
                end
                REG_HEIGHT: begin
                    height_cfg = value[DIM_W-1:0];
                end
                REG_KEY: begin
                    key_cfg = value[KEY_W-1:0];
                end
                default: begin
                end
            endcase
        endfunction

        function int unsigned dim_limit(input logic [DIM_W-1:0] v);
            if (v == '0) return 1;
            if (v > MAX_DIM) return MAX_DIM;
            return v;
        endfunction

        function void queue_token(input t_kind k, input logic [31:0] w,
                                  input logic [31:0] first, input logic [31:0] final_row,
                                  input logic [31:0] col, input logic fin);
            rle_token_t t;
            t.kind       = k;
            t.word       = w;
            t.row_first  = first[DIM_W-1:0];
            t.row_last   = final_row[DIM_W-1:0];
            t.run_column = col[COL_W-1:0];
            t.last       = fin;
            due_tokens.push_back(t);
        endfunction

        function void close_run();
            queue_token(KIND_LENGTH, (col_pos - mark_col) * 32'd2, '0, '0, '0, 1'b0);
            mark_col = col_pos;
            mark_row = row_pos;
            run_open = 1'b0;
        endfunction

        // Expected tokens for one accepted pixel word
        function void note_pixel(input logic [PIX_W-1:0] px);
            int unsigned w;
            int unsigned h;
            logic [31:0] skip;
            logic [31:0] rgb;
            w = dim_limit(width_cfg);
            h = dim_limit(height_cfg);
            if (px == key_cfg) begin
                if (run_open) close_run();
            end else begin
                if (!run_open) begin
                    skip = (row_pos - mark_row) * 32'(pitch_cfg) + (col_pos - mark_col) * 32'd2;
                    if (row_pos != mark_row) skip = skip | ROW_CHANGED_BIT;
                    queue_token(KIND_SKIP, skip, '0, '0, '0, 1'b0);
                    queue_token(KIND_RANGE, '0, listed_row + 32'd1, row_pos, col_pos, 1'b0);
                    listed_row = row_pos;
                    mark_col   = col_pos;
                    mark_row   = row_pos;
                    run_open   = 1'b1;
                end
                rgb = ((32'(px[23:16]) >> 3) << 11) | ((32'(px[15:8]) >> 2) << 5)
                    | (32'(px[7:0]) >> 3);
                queue_token(KIND_PIXEL, rgb, '0, '0, '0, 1'b0);
            end

            // Advance the raster position; close the row and the image at their ends
            col_pos = col_pos + 32'd1;
            if (col_pos >= w) begin
                if (run_open) close_run();
                col_pos = '0;
                row_pos = row_pos + 32'd1;
                if (row_pos >= h) begin
                    queue_token(KIND_TERM, TERMINATOR_WORD, '0, '0, '0, 1'b0);
                    queue_token(KIND_NULL, '0, listed_row + 32'd1, h, '0, 1'b1);
                    restart();
                end
            end
        endfunction

        task report(input string msg);
            mismatch_count++;
            if (mismatch_count <= PRINT_LIMIT) $display("mismatch at %0t: %s", $realtime, msg);
        endtask

        task check_token(input rle_token_t got);
            rle_token_t want;
            if (due_tokens.size() == 0) begin
                report($sformatf("token kind %0d word %h with nothing due", got.kind, got.word));
                return;
            end
            want = due_tokens.pop_front();
            if (got.kind !== want.kind)
                report($sformatf("kind %0d, want %0d", got.kind, want.kind));
            if (got.word !== want.word)
                report($sformatf("word %h, want %h (kind %0d)", got.word, want.word, want.kind));
            if (got.row_first !== want.row_first)
                report($sformatf("row_first %0d, want %0d", got.row_first, want.row_first));
            if (got.row_last !== want.row_last)
                report($sformatf("row_last %0d, want %0d", got.row_last, want.row_last));
            if (got.run_column !== want.run_column)
                report($sformatf("run_column %0d, want %0d", got.run_column, want.run_column));
            if (got.last !== want.last)
                report($sformatf("last %0b, want %0b (kind %0d)", got.last, want.last, want.kind));
        endtask

        function int pending();
            return due_tokens.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic pready;
    bit   no_idle = 1'b0;

    scrle_pix_if pix ();
    scrle_tok_if tok ();

    rle_token_scoreboard encoder_check = new();

    sprite_colour_key_rle_encoder_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix),
        .o_tok   (tok),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Note accepted pixels and check accepted tokens
    always @(posedge i_clk) begin : watch_ports
        rle_token_t seen;
        if (i_rst_n) begin
            if (pix.valid && pix.ready) encoder_check.note_pixel(pix.pixel);
            if (tok.valid && tok.ready) begin
                seen.kind       = t_kind'(tok.kind);
                seen.word       = tok.word;
                seen.row_first  = tok.row_first;
                seen.row_last   = tok.row_last;
                seen.run_column = tok.run_column;
                seen.last       = tok.last;
                encoder_check.check_token(seen);
            end
        end
    end

    // Token receiver: stall a random number of cycles before each word
    initial begin
        int stall;
        tok.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0) begin
                tok.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            tok.ready <= 1'b1;
            do @(posedge i_clk); while (!tok.valid);
        end
    end

    // Watchdog: end the run when nothing moves for too long
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        do @(posedge i_clk); while (!i_rst_n);
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((pix.valid && pix.ready) || (tok.valid && tok.ready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("testbench NOT OK");
        $finish;
    end

    // Offer one pixel word after a random gap and hold it until taken
    task automatic send_pixel(input logic [PIX_W-1:0] px);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            pix.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix.valid <= 1'b1;
        pix.pixel <= px;
        do @(posedge i_clk); while (!pix.ready);
    endtask

    // Hold the sender until every due token has arrived, then let the block settle
    task automatic settle();
        pix.valid <= 1'b0;
        do @(posedge i_clk); while (encoder_check.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [1:0] reg_index, input logic [PDATA_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_index, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        encoder_check.set_register(reg_index, value);
    endtask

    task automatic configure(input logic [PITCH_W-1:0] pitch, input logic [DIM_W-1:0] width,
                             input logic [DIM_W-1:0] height, input logic [KEY_W-1:0] key);
        apb_write(REG_PITCH, PDATA_W'(pitch));
        apb_write(REG_WIDTH, PDATA_W'(width));
        apb_write(REG_HEIGHT, PDATA_W'(height));
        apb_write(REG_KEY, PDATA_W'(key));
    endtask

    // Mostly key or opaque runs, with near-key colours mixed in
    function automatic logic [PIX_W-1:0] pick_pixel(input logic [KEY_W-1:0] key);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 40) return key;
        if (roll < 50) return key ^ (24'd1 << $urandom_range(0, PIX_W - 1));
        return PIX_W'($urandom());
    endfunction

    initial begin
        logic [PITCH_W-1:0] pitch_now;
        logic [KEY_W-1:0]   key_now;
        i_rst_n   <= 1'b0;
        pix.valid <= 1'b0;
        pix.pixel <= '0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: one short run between key pixels, image left open mid-image
        send_pixel(24'h000000);
        send_pixel(24'hffffff);
        send_pixel(24'h123456);
        send_pixel(24'h000000);
        settle();

        // Shrink the image under the current position, widest pitch, white key
        configure(16'hffff, 13'd3, 13'd2, 24'hffffff);
        foreach (RUN_PIXELS[k]) send_pixel(RUN_PIXELS[k]);
        settle();

        // Zero dimensions clamp to a single-pixel image
        configure(16'h0000, 13'd0, 13'd0, 24'h000000);
        send_pixel(24'h000000);
        send_pixel(24'habcdef);
        settle();

        // Oversized dimensions clamp to the maximum; leave the image open
        configure(16'd1, 13'h1fff, 13'h1fff, 24'h5a5a5a);
        send_pixel(24'h5a5a5a);
        send_pixel(24'h5a5a5b);
        send_pixel(24'ha5a5a5);
        settle();

        // Random small images, one setting per phase
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            no_idle = (phase == 2);
            case ($urandom_range(0, 3))
                0: pitch_now = '0;
                1: pitch_now = '1;
                default: pitch_now = PITCH_W'($urandom());
            endcase
            case ($urandom_range(0, 3))
                0: key_now = '0;
                1: key_now = '1;
                default: key_now = KEY_W'($urandom());
            endcase
            configure(pitch_now, DIM_W'($urandom_range(0, 6)), DIM_W'($urandom_range(1, 4)),
                      key_now);
            for (int n = 0; n < PHASE_PIXELS; n++) send_pixel(pick_pixel(key_now));
            settle();
        end
        no_idle = 1'b0;

        if (encoder_check.pending() != 0)
            encoder_check.report($sformatf("%0d tokens never arrived", encoder_check.pending()));
        if (encoder_check.mismatch_count == 0) $display("testbench OK");
        else $display("testbench NOT OK");
        $finish;
    end

endmodule

// File: sprite_colour_key_rle_encoder_top.f
design/scrle_pkg.sv
design/scrle_if.sv
design/scrle_front.sv
design/scrle_fifo.sv
design/scrle_back.sv
design/sprite_colour_key_rle_encoder_top.sv
dv/testbench.sv
